@@ hdl/int64_to_decimal_ascii_defines.svh @@
// assertion macros shared by the converter rtl
// no dependencies; taken in by `include where assertions are written
`ifndef INT64_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT64_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2DA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2da assertion failed");

// next-cycle implication, checked outside reset
`define I2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2da assertion failed");

`endif

@@ hdl/i2da_pkg.sv @@
// shared constants and types for the binary to decimal ascii converter
// no dependencies
package i2da_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_DIGITS_DEF  = 20;
   localparam int IN_WIDTH        = 64;
   localparam int DIGIT_W         = 4;
   localparam int CHAR_W          = 8;
   localparam int COUNT_W         = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // per-cycle command to every cell of the digit chain
   typedef struct packed {
      logic clear;   // load zero
      logic conv;    // add-3 adjust and shift in the neighbour's carry
      logic shift;   // take the lower neighbour's digit
   } cell_ctrl_type;

endpackage

@@ hdl/int64_to_decimal_ascii.sv @@
// Binary to decimal ASCII converter. Each req beat carries a 64-bit value and
// a kind flag (0 unsigned, 1 two's-complement signed, sign bit VALUE_WIDTH-1;
// bits above VALUE_WIDTH are ignored). The decimal text leaves as rsp beats,
// one character each, most significant digit first, with rsp_last on the
// final one; a negative value opens with '-', zero gives a single '0', and no
// leading zeros appear. At most MAX_DIGITS characters are given, sign
// included; if the text is longer only the low-order digits that fit are
// kept. The conversion runs in a chain of BCD cells (double dabble): the
// magnitude is shifted in one bit per cycle, then the sign goes out when
// negative, and the chain shifts its digits upward once per cycle past the
// output register whenever that register can take a character. One item is
// in work at a time; the next is taken while the last character still waits
// in the output register.
// depends on i2da_pkg, i2da_cell and int64_to_decimal_ascii_defines.svh
`include "int64_to_decimal_ascii_defines.svh"

module int64_to_decimal_ascii
   import i2da_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [IN_WIDTH-1:0]  req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAR_W-1:0]    rsp_ascii_char,
   output logic                 rsp_last
);

   // decimal digits of the widest value: floor(width * log10(2)) + 1
   localparam int NUM_CELLS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int POS_W     = $clog2(NUM_CELLS);
   localparam int BITCNT_W  = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_SCAN = 2'd3;

   logic [1:0]             state_ff,   state_in;
   logic [VALUE_WIDTH-1:0] mag_ff,     mag_in;
   logic [BITCNT_W-1:0]    bitcnt_ff,  bitcnt_in;
   logic [POS_W-1:0]       pos_ff,     pos_in;
   logic                   neg_ff,     neg_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff,  rsp_char_in;
   logic                   rsp_last_ff,  rsp_last_in;

   logic                   req_take;
   logic                   out_free;
   logic [VALUE_WIDTH-1:0] v_raw;
   logic                   v_neg;
   logic [COUNT_W-1:0]     limit;
   logic [DIGIT_W-1:0]     top_digit;
   logic                   emit;
   cell_ctrl_type          ctrl;

   logic [NUM_CELLS:0]     carry;
   logic [DIGIT_W-1:0]     digit [NUM_CELLS];
   logic [DIGIT_W-1:0]     nb    [NUM_CELLS];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // magnitude by negate at the configured width
   assign v_raw = req_value[VALUE_WIDTH-1:0];
   assign v_neg = req_func && v_raw[VALUE_WIDTH-1];

   // digits allowed after the optional sign
   assign limit     = COUNT_W'(MAX_DIGITS) - COUNT_W'(neg_ff);
   assign top_digit = digit[NUM_CELLS-1];

   // a digit goes out once the number has started, the units digit always,
   // and never above the character limit
   assign emit = (COUNT_W'(pos_ff) < limit)
              && (started_ff || (top_digit != '0) || (pos_ff == '0));

   // digit chain: carries run up through the cells in conversion,
   // digits move up one cell per cycle in the scan while the output is free
   assign carry[0] = mag_ff[VALUE_WIDTH-1];

   always_comb begin
      ctrl.clear = req_take;
      ctrl.conv  = (state_ff == ST_CONV);
      ctrl.shift = (state_ff == ST_SCAN) && out_free;
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign nb[i] = '0;
      end else begin : g_rest
         assign nb[i] = digit[i-1];
      end

      i2da_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .carry_in  (carry[i]),
         .nb_digit  (nb[i]),
         .carry_out (carry[i+1]),
         .digit     (digit[i])
      );
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bitcnt_in    = bitcnt_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in    = v_neg;
               mag_in    = v_neg ? (~v_raw + VALUE_WIDTH'(1)) : v_raw;
               bitcnt_in = BITCNT_W'(VALUE_WIDTH);
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            // one magnitude bit per cycle into the bottom cell
            mag_in    = mag_ff << 1;
            bitcnt_in = bitcnt_ff - BITCNT_W'(1);
            if (bitcnt_ff == BITCNT_W'(1)) begin
               pos_in     = POS_W'(NUM_CELLS - 1);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_SCAN;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               started_in = started_ff || (top_digit != '0);
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = CHAR_ZERO + CHAR_W'(top_digit);
                  rsp_last_in  = (pos_ff == '0);
               end
               pos_in = pos_ff - POS_W'(1);
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bitcnt_ff    <= '0;
         pos_ff       <= '0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bitcnt_ff    <= bitcnt_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   // the chain is sized for the widest value, so nothing leaves the top cell
   `I2DA_ASSERT_IMPL(a_no_top_carry, clock, reset, state_ff == ST_CONV, !carry[NUM_CELLS])
   // every scanned digit is a proper decimal digit
   `I2DA_ASSERT_IMPL(a_bcd_digit, clock, reset, state_ff == ST_SCAN, top_digit <= DIGIT_W'(9))
   // an accepted beat starts the conversion
   `I2DA_ASSERT_NEXT(a_take_conv, clock, reset, req_take, state_ff == ST_CONV)
   // the units digit ends the scan and is always the last character
   `I2DA_ASSERT_NEXT(a_scan_end, clock, reset,
      (state_ff == ST_SCAN) && out_free && (pos_ff == '0),
      (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
   // the sign never closes a number
   `I2DA_ASSERT_IMPL(a_sign_not_last, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_char_ff != CHAR_MINUS)

endmodule

@@ hdl/i2da_cell.sv @@
// one decimal digit cell of the conversion chain
// depends on i2da_pkg
module i2da_cell
   import i2da_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic                carry_in,
   input  logic [DIGIT_W-1:0]  nb_digit,
   output logic                carry_out,
   output logic [DIGIT_W-1:0]  digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // add 3 when the digit would overflow past nine on doubling
   assign adj       = (digit_ff >= DIGIT_W'(5)) ? digit_ff + DIGIT_W'(3) : digit_ff;
   assign carry_out = adj[DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.conv) begin
         digit_in = {adj[DIGIT_W-2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_in = nb_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

@@ tb/int64_to_decimal_ascii_checker.sv @@
// scoreboard for the binary to decimal ascii converter: works out the text of
// every accepted req beat and compares the rsp beats against it in order
// depends on i2da_pkg
module int64_to_decimal_ascii_checker
   import i2da_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_func,
   input  logic [IN_WIDTH-1:0] req_value,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CHAR_W-1:0]   rsp_ascii_char,
   input  logic                rsp_last,
   output int                  mismatches,
   output int                  outstanding
);

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
   } text_beat_type;

   text_beat_type expected_text[$];
   int            fail_total = 0;
   int            chars_due  = 0;

   assign mismatches  = fail_total;
   assign outstanding = chars_due;

   // decimal text of one number: optional '-', then digits most significant first
   task automatic predict_decimal_text(input logic is_signed,
                                       input logic [IN_WIDTH-1:0] raw);
      logic                negative;
      logic [IN_WIDTH-1:0] magnitude;
      logic [IN_WIDTH-1:0] rem;
      logic [CHAR_W-1:0]   digits[$];
      text_beat_type       beat;
      int                  n;
      begin
         raw      = raw & ({IN_WIDTH{1'b1}} >> (IN_WIDTH - VALUE_WIDTH_DEF));
         negative = is_signed && raw[VALUE_WIDTH_DEF-1];
         magnitude = negative ? ((~raw + 1'b1)
                                 & ({IN_WIDTH{1'b1}} >> (IN_WIDTH - VALUE_WIDTH_DEF)))
                              : raw;
         do begin
            rem = magnitude % 64'd10;
            digits.push_front(CHAR_ZERO + rem[CHAR_W-1:0]);
            magnitude = magnitude / 64'd10;
         end while (magnitude != 0);
         // keep only the low-order digits that fit beside the sign
         while (digits.size() > MAX_DIGITS_DEF - int'(negative))
            void'(digits.pop_front());
         if (negative)
            digits.push_front(CHAR_MINUS);
         for (n = 0; n < digits.size(); n++) begin
            beat.ascii_char = digits[n];
            beat.last       = (n == digits.size() - 1);
            expected_text.insert(expected_text.size(), beat);
         end
         chars_due += digits.size();
      end
   endtask

   always @(posedge clock) begin : compare_beats
      text_beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected rsp beat: expected none, actual char %h last %b",
                        $time, rsp_ascii_char, rsp_last);
               fail_total++;
            end else begin
               want = expected_text.pop_front();
               chars_due--;
               if (rsp_ascii_char !== want.ascii_char) begin
                  $display("%0t: ascii_char mismatch: expected %h actual %h",
                           $time, want.ascii_char, rsp_ascii_char);
                  fail_total++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %b actual %b",
                           $time, want.last, rsp_last);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_decimal_text(req_func, req_value);
      end
   end

endmodule

@@ tb/int64_to_decimal_ascii_tb.sv @@
// top of the converter testbench: clock, reset, req stimulus and rsp pacing
// depends on i2da_pkg, int64_to_decimal_ascii and int64_to_decimal_ascii_checker
module int64_to_decimal_ascii_tb;
   import i2da_pkg::*;

   // covers a slow item: its conversion, a send gap and up to 20 characters
   // each held off by the receiver
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int DRAIN_CYCLES  = 200;
   localparam int RANDOM_ITEMS  = 78;
   localparam int MAX_IDLE      = 18;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic                req_func       = 1'b0;
   logic [IN_WIDTH-1:0] req_value      = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [CHAR_W-1:0]   rsp_ascii_char;
   logic                rsp_last;

   int mismatch_total;
   int chars_outstanding;
   int cycle_count = 0;

   // sender side: long stretches of back-to-back beats come from this flag
   logic tx_quiet = 1'b0;

   int64_to_decimal_ascii u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   int64_to_decimal_ascii_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .mismatches     (mismatch_total),
      .outstanding    (chars_outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [IN_WIDTH-1:0] power_of_ten(input int exponent);
      logic [IN_WIDTH-1:0] acc;
      acc = IN_WIDTH'(1);
      for (int n = 0; n < exponent; n++)
         acc = acc * IN_WIDTH'(10);
      return acc;
   endfunction

   // one req beat: optional idle gap, then hold the beat until it is taken.
   // with no gap valid simply stays high and the payload moves on, so valid
   // never gets two assignments in the same step
   task automatic send_number(input logic kind, input logic [IN_WIDTH-1:0] raw);
      int unsigned gap;
      begin
         if ($urandom_range(0, 11) == 0)
            tx_quiet = !tx_quiet;
         gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_func  <= kind;
         req_value <= raw;
         do @(posedge clock); while (req_stall);
      end
   endtask

   // receiver side: after every accepted rsp beat draw a hold-off, with
   // quiet stretches where the stall never rises
   initial begin : rsp_pacing
      int unsigned hold;
      logic        rx_quiet;
      rx_quiet = 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0)
            rx_quiet = !rx_quiet;
         hold = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int unsigned         shape;
      logic                kind;
      logic [IN_WIDTH-1:0] raw;
      int                  exponent;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: unsigned extremes, digit-count boundaries, alternating bits
      send_number(1'b0, 64'd0);
      send_number(1'b0, 64'd1);
      send_number(1'b0, 64'd9);
      send_number(1'b0, 64'd10);
      send_number(1'b0, 64'd99);
      send_number(1'b0, 64'd100);
      send_number(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(1'b0, power_of_ten(19));
      send_number(1'b0, power_of_ten(19) - 1);
      send_number(1'b0, 64'h8000_0000_0000_0000);
      send_number(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
      send_number(1'b0, 64'h5555_5555_5555_5555);
      // directed signed: zero, small of both signs, most positive, most negative
      send_number(1'b1, 64'd0);
      send_number(1'b1, 64'd1);
      send_number(1'b1, 64'd9);
      send_number(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(1'b1, ~64'd9 + 1'b1);
      send_number(1'b1, ~64'd10 + 1'b1);
      send_number(1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
      send_number(1'b1, 64'h8000_0000_0000_0000);
      send_number(1'b1, 64'h8000_0000_0000_0001);
      send_number(1'b1, 64'h5555_5555_5555_5555);

      // random: full-width, short, near powers of ten, sign-bit set, tiny
      repeat (RANDOM_ITEMS) begin
         kind  = 1'($urandom_range(0, 1));
         shape = $urandom_range(0, 4);
         case (shape)
            0: begin
               raw = {$urandom, $urandom};
            end
            1: begin
               raw = {$urandom, $urandom} >> $urandom_range(1, 63);
               if (kind && $urandom_range(0, 1))
                  raw = ~raw + 1'b1;
            end
            2: begin
               exponent = $urandom_range(0, 19);
               raw = power_of_ten(exponent) - 1 + $urandom_range(0, 2);
               if (kind && $urandom_range(0, 1))
                  raw = ~raw + 1'b1;
            end
            3: begin
               raw = {1'b1, 31'($urandom), $urandom};
            end
            default: begin
               raw = IN_WIDTH'($urandom_range(0, 20));
               if (kind && $urandom_range(0, 1))
                  raw = ~raw + 1'b1;
            end
         endcase
         send_number(kind, raw);
      end

      req_valid <= 1'b0;
      // let the last beat reach the checker before looking at the backlog
      @(posedge clock);
      while (chars_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_total == 0 && chars_outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
